@@ rtl/srwm_pkg.sv @@
// Shared types and constants for the serial register write master.
// No dependencies; imported by serial_register_write_master_unit.
package srwm_pkg;

    // Number of chip select lines in use and length of the shifted word.
    localparam int NUM_CHIPS = 8;
    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = $clog2(WORD_BITS);
    localparam int TICK_W    = 16;
    localparam int SEL_W     = 8;

    // Reset values of the timing registers.
    localparam logic [TICK_W-1:0] SELECT_SETUP_RESET = 16'd10;
    localparam logic [TICK_W-1:0] DATA_SETUP_RESET   = 16'd10;
    localparam logic [TICK_W-1:0] CLOCK_HIGH_RESET   = 16'd25;
    localparam logic [TICK_W-1:0] CLOCK_LOW_RESET    = 16'd25;
    localparam logic [TICK_W-1:0] END_GAP_RESET      = 16'd1000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SELECT_SETUP = 3'd0;
    localparam logic [2:0] CFG_DATA_SETUP   = 3'd1;
    localparam logic [2:0] CFG_CLOCK_HIGH   = 3'd2;
    localparam logic [2:0] CFG_CLOCK_LOW    = 3'd3;
    localparam logic [2:0] CFG_END_GAP      = 3'd4;

    // Request command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Phases of one serial write.
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_SEL_SETUP  = 3'd1,
        PH_DATA_SETUP = 3'd2,
        PH_CLK_HIGH   = 3'd3,
        PH_CLK_LOW    = 3'd4,
        PH_END_GAP    = 3'd5
    } phase_t;

    // Input request.
    typedef struct packed {
        logic        command;
        logic [2:0]  target_chip;
        logic [3:0]  reg_address;
        logic [27:0] reg_data;
    } req_t;

    // Pin levels and status after one request.
    typedef struct packed {
        logic             serial_clock;
        logic             serial_data;
        logic [SEL_W-1:0] select_lines_n;
        logic             busy_res;
        logic             rejected;
        logic             write_done;
    } res_t;

endpackage

@@ rtl/serial_register_write_master_unit.sv @@
// Top level of the serial register write master: timing registers, phase
// sequencer and result register. Depends on srwm_pkg.
//
// Usage: each request on the s_ channel is either a tick (one unit of time
// passes) or a write request that names a chip, a 4-bit register address and
// 28-bit data. For every request exactly one result appears on the m_
// channel, carrying the serial clock, data and active-low select levels
// after that request, plus busy, rejected and write-done flags.
// A write request while a write or its end gap is in progress is rejected.
// Each result is registered, valid in the cycle after its request is taken.
// One request is taken every cycle while the receiver keeps up, as a single
// phase/counter update lies between request and result register. When the
// receiver stalls, the result is held and s_ready falls until it is taken.
// Timing registers are written through cfg_wr_en / cfg_index / cfg_wdata
// and take effect at once. Reset (aresetn low, synchronous) restores the
// timing defaults, returns the sequencer to idle with all selects high, and
// empties the result register.
module serial_register_write_master_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [15:0]              cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  srwm_pkg::req_t           s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output srwm_pkg::res_t           m_data
);
    import srwm_pkg::*;

    logic [TICK_W-1:0]    select_setup_reg;
    logic [TICK_W-1:0]    data_setup_reg;
    logic [TICK_W-1:0]    clock_high_reg;
    logic [TICK_W-1:0]    clock_low_reg;
    logic [TICK_W-1:0]    end_gap_reg;

    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [2:0]           active_chip_reg, active_chip_next;
    logic                 clock_level_reg, clock_level_next;
    logic                 data_level_reg, data_level_next;
    logic                 select_asserted_reg, select_asserted_next;

    res_t                 res_reg, res_next;
    logic                 out_valid_reg;

    logic                 accept;
    logic [TICK_W-1:0]    tick_inc;
    logic [TICK_W-1:0]    phase_len;
    logic                 phase_over;
    logic                 rejected;
    logic                 done;
    logic [SEL_W-1:0]     sel_pins;
    logic [31:0]          full_word;

    // A request is taken whenever the result register is free or drains now.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = res_reg;

    // Timing registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_setup_reg <= SELECT_SETUP_RESET;
            data_setup_reg   <= DATA_SETUP_RESET;
            clock_high_reg   <= CLOCK_HIGH_RESET;
            clock_low_reg    <= CLOCK_LOW_RESET;
            end_gap_reg      <= END_GAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SELECT_SETUP: select_setup_reg <= cfg_wdata;
                CFG_DATA_SETUP:   data_setup_reg   <= cfg_wdata;
                CFG_CLOCK_HIGH:   clock_high_reg   <= cfg_wdata;
                CFG_CLOCK_LOW:    clock_low_reg    <= cfg_wdata;
                CFG_END_GAP:      end_gap_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Length of the current phase; a phase ends when the incremented count
    // reaches it, or when the count wraps.
    always_comb begin
        case (phase_reg)
            PH_SEL_SETUP:  phase_len = select_setup_reg;
            PH_DATA_SETUP: phase_len = data_setup_reg;
            PH_CLK_HIGH:   phase_len = clock_high_reg;
            PH_CLK_LOW:    phase_len = clock_low_reg;
            PH_END_GAP:    phase_len = end_gap_reg;
            default:       phase_len = '0;
        endcase
    end

    assign tick_inc   = tick_count_reg + TICK_W'(1);
    assign phase_over = (tick_inc >= phase_len) || (tick_inc == '0);
    assign full_word  = {s_data.reg_data, s_data.reg_address};

    // Sequencer: next state and result flags for the current request.
    always_comb begin
        phase_next           = phase_reg;
        tick_count_next      = tick_count_reg;
        bit_index_next       = bit_index_reg;
        shift_word_next      = shift_word_reg;
        active_chip_next     = active_chip_reg;
        clock_level_next     = clock_level_reg;
        data_level_next      = data_level_reg;
        select_asserted_next = select_asserted_reg;
        rejected             = 1'b0;
        done                 = 1'b0;

        if (s_data.command == CMD_WRITE) begin
            if (phase_reg != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                shift_word_next      = full_word[WORD_BITS-1:0];
                active_chip_next     = s_data.target_chip;
                select_asserted_next = 1'b1;
                clock_level_next     = 1'b0;
                tick_count_next      = '0;
                bit_index_next       = BIT_IDX_W'(WORD_BITS - 1);
                phase_next           = PH_SEL_SETUP;
            end
        end else begin
            if (phase_reg != PH_IDLE) begin
                tick_count_next = phase_over ? '0 : tick_inc;
            end
            case (phase_reg)
                PH_IDLE: ;
                PH_SEL_SETUP: begin
                    if (phase_over) begin
                        data_level_next = shift_word_reg[bit_index_reg];
                        phase_next      = PH_DATA_SETUP;
                    end
                end
                PH_DATA_SETUP: begin
                    if (phase_over) begin
                        clock_level_next = 1'b1;
                        phase_next       = PH_CLK_HIGH;
                    end
                end
                PH_CLK_HIGH: begin
                    if (phase_over) begin
                        clock_level_next = 1'b0;
                        phase_next       = PH_CLK_LOW;
                    end
                end
                PH_CLK_LOW: begin
                    if (phase_over) begin
                        if (bit_index_reg == '0) begin
                            select_asserted_next = 1'b0;
                            phase_next           = PH_END_GAP;
                        end else begin
                            bit_index_next  = bit_index_reg - BIT_IDX_W'(1);
                            data_level_next = shift_word_reg[bit_index_reg - BIT_IDX_W'(1)];
                            phase_next      = PH_DATA_SETUP;
                        end
                    end
                end
                PH_END_GAP: begin
                    if (phase_over) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Active-low selects; a chip index beyond the wired lines drives none.
    always_comb begin
        sel_pins = '1;
        if (select_asserted_next && ({1'b0, active_chip_next} < 4'(NUM_CHIPS))) begin
            sel_pins[active_chip_next] = 1'b0;
        end
    end

    // Result assembled from the state after this request.
    always_comb begin
        res_next.serial_clock   = clock_level_next;
        res_next.serial_data    = data_level_next;
        res_next.select_lines_n = sel_pins;
        res_next.busy_res       = (phase_next != PH_IDLE);
        res_next.rejected       = rejected;
        res_next.write_done     = done;
    end

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            tick_count_reg      <= '0;
            bit_index_reg       <= '0;
            shift_word_reg      <= '0;
            active_chip_reg     <= '0;
            clock_level_reg     <= 1'b0;
            data_level_reg      <= 1'b0;
            select_asserted_reg <= 1'b0;
        end else if (accept) begin
            phase_reg           <= phase_next;
            tick_count_reg      <= tick_count_next;
            bit_index_reg       <= bit_index_next;
            shift_word_reg      <= shift_word_next;
            active_chip_reg     <= active_chip_next;
            clock_level_reg     <= clock_level_next;
            data_level_reg      <= data_level_next;
            select_asserted_reg <= select_asserted_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for serial_register_write_master_unit: drives tick and write
// requests, predicts the serial pin levels of every result and compares them. Needs srwm_pkg.
module testbench;
    import srwm_pkg::*;

    // Register indexes above the last timing register address nothing.
    localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;

    // Tracks the expected pin levels of the write master and checks each result.
    class pin_scoreboard;
        logic [15:0] timing [5];
        phase_t      seq_phase;
        logic [15:0] tick_count;
        logic [4:0]  bit_index;
        logic [31:0] shift_word;
        logic [2:0]  active_chip;
        logic        clk_lvl;
        logic        dat_lvl;
        logic        sel_on;
        res_t        levels_due [$];
        bit          failed;

        function new();
            timing[CFG_SELECT_SETUP] = SELECT_SETUP_RESET;
            timing[CFG_DATA_SETUP]   = DATA_SETUP_RESET;
            timing[CFG_CLOCK_HIGH]   = CLOCK_HIGH_RESET;
            timing[CFG_CLOCK_LOW]    = CLOCK_LOW_RESET;
            timing[CFG_END_GAP]      = END_GAP_RESET;
            seq_phase   = PH_IDLE;
            tick_count  = '0;
            bit_index   = '0;
            shift_word  = '0;
            active_chip = '0;
            clk_lvl     = 1'b0;
            dat_lvl     = 1'b0;
            sel_on      = 1'b0;
            failed      = 1'b0;
        endfunction

        // Writes to indexes past the timing registers are dropped.
        function void set_register(logic [2:0] idx, logic [15:0] val);
            if (idx <= CFG_END_GAP) begin
                timing[idx] = val;
            end
        endfunction

        function bit busy();
            return seq_phase != PH_IDLE;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // Counts one tick; a length of zero behaves like one.
        function bit span_elapsed(logic [15:0] len);
            tick_count = tick_count + 16'd1;
            if (tick_count >= len || tick_count == 16'd0) begin
                tick_count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advances the waveform by one request and queues the resulting levels.
        function void note_request(req_t r);
            res_t lv;
            logic rej;
            logic done;
            rej  = 1'b0;
            done = 1'b0;
            if (r.command == CMD_WRITE) begin
                if (seq_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    shift_word  = {r.reg_data, r.reg_address};
                    active_chip = r.target_chip;
                    sel_on      = 1'b1;
                    clk_lvl     = 1'b0;
                    tick_count  = '0;
                    bit_index   = 5'(WORD_BITS - 1);
                    seq_phase   = PH_SEL_SETUP;
                end
            end else begin
                case (seq_phase)
                    PH_SEL_SETUP: begin
                        if (span_elapsed(timing[CFG_SELECT_SETUP])) begin
                            dat_lvl   = shift_word[bit_index];
                            seq_phase = PH_DATA_SETUP;
                        end
                    end
                    PH_DATA_SETUP: begin
                        if (span_elapsed(timing[CFG_DATA_SETUP])) begin
                            clk_lvl   = 1'b1;
                            seq_phase = PH_CLK_HIGH;
                        end
                    end
                    PH_CLK_HIGH: begin
                        if (span_elapsed(timing[CFG_CLOCK_HIGH])) begin
                            clk_lvl   = 1'b0;
                            seq_phase = PH_CLK_LOW;
                        end
                    end
                    PH_CLK_LOW: begin
                        if (span_elapsed(timing[CFG_CLOCK_LOW])) begin
                            if (bit_index == 5'd0) begin
                                sel_on    = 1'b0;
                                seq_phase = PH_END_GAP;
                            end else begin
                                bit_index = bit_index - 5'd1;
                                dat_lvl   = shift_word[bit_index];
                                seq_phase = PH_DATA_SETUP;
                            end
                        end
                    end
                    PH_END_GAP: begin
                        if (span_elapsed(timing[CFG_END_GAP])) begin
                            seq_phase = PH_IDLE;
                            done      = 1'b1;
                        end
                    end
                    default: begin
                        seq_phase = PH_IDLE;
                    end
                endcase
            end
            lv.serial_clock   = clk_lvl;
            lv.serial_data    = dat_lvl;
            lv.select_lines_n = '1;
            if (sel_on && active_chip < NUM_CHIPS) begin
                lv.select_lines_n[active_chip] = 1'b0;
            end
            lv.busy_res   = seq_phase != PH_IDLE;
            lv.rejected   = rej;
            lv.write_done = done;
            levels_due.push_back(lv);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failed = 1'b1;
            end
        endfunction

        // Compares one result with the oldest expected levels.
        function void check_levels(res_t got);
            res_t want;
            if (levels_due.size() == 0) begin
                $error("result with no request outstanding: %0h", got);
                failed = 1'b1;
                return;
            end
            want = levels_due.pop_front();
            compare_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
            compare_field("serial_data", 8'(want.serial_data), 8'(got.serial_data));
            compare_field("select_lines_n", 8'(want.select_lines_n), 8'(got.select_lines_n));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
            compare_field("write_done", 8'(want.write_done), 8'(got.write_done));
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    req_t        s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b1;
    res_t        m_data;

    pin_scoreboard levels;
    int gap_odds   = 0;
    int stall_odds = 0;
    int sent_items = 0;

    serial_register_write_master_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: ready stays high except for random stall bursts.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Every accepted result is checked against the prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            levels.check_levels(m_data);
        end
    end

    function automatic req_t random_request(logic cmd);
        req_t r;
        r.command     = cmd;
        r.target_chip = 3'($urandom_range(0, 7));
        r.reg_address = 4'($urandom_range(0, 15));
        r.reg_data    = 28'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] random_length();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(4, 30));
        end
        return 16'($urandom_range(0, 3));
    endfunction

    // Offers one request, possibly after a gap, and waits until it is taken.
    task automatic send_request(input req_t r);
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        levels.note_request(r);
        sent_items++;
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (levels.pending() != 0);
    endtask

    // Starts one write and ticks it through to the end of its gap; a rejected
    // write request is slipped in at tick reject_at when that is nonzero.
    task automatic run_write(input logic [2:0] chip, input logic [3:0] addr,
                             input logic [27:0] data, input int reject_at);
        req_t r;
        int   n;
        r             = random_request(CMD_WRITE);
        r.target_chip = chip;
        r.reg_address = addr;
        r.reg_data    = data;
        send_request(r);
        n = 0;
        while (levels.busy()) begin
            n++;
            send_request(random_request(n == reject_at ? CMD_WRITE : CMD_TICK));
        end
    endtask

    // Starts one write and sends a fixed number of ticks after it, so the write
    // may still be running; a rejected write request goes in at tick reject_at.
    task automatic start_write(input logic [2:0] chip, input logic [3:0] addr,
                               input logic [27:0] data, input int ticks,
                               input int reject_at);
        req_t r;
        int   n;
        r             = random_request(CMD_WRITE);
        r.target_chip = chip;
        r.reg_address = addr;
        r.reg_data    = data;
        send_request(r);
        for (n = 1; n <= ticks; n++) begin
            send_request(random_request(n == reject_at ? CMD_WRITE : CMD_TICK));
        end
    endtask

    // Ticks the write in progress through to the end of its gap.
    task automatic finish_write();
        while (levels.busy()) begin
            send_request(random_request(CMD_TICK));
        end
    endtask

    // Loads all timing registers, plus one write to an unused index, once every outstanding result is back.
    task automatic program_timing(input logic [15:0] sel_setup, input logic [15:0] dat_setup,
                                  input logic [15:0] clk_high, input logic [15:0] clk_low,
                                  input logic [15:0] end_gap);
        logic [2:0]  idx  [6];
        logic [15:0] vals [6];
        int          i;
        idx[0]  = CFG_SELECT_SETUP;
        idx[1]  = CFG_DATA_SETUP;
        idx[2]  = CFG_CLOCK_HIGH;
        idx[3]  = CFG_CLOCK_LOW;
        idx[4]  = CFG_END_GAP;
        idx[5]  = CFG_FIRST_UNUSED + 3'($urandom_range(0, 2));
        vals[0] = sel_setup;
        vals[1] = dat_setup;
        vals[2] = clk_high;
        vals[3] = clk_low;
        vals[4] = end_gap;
        vals[5] = 16'($urandom);
        drain();
        repeat (4) @(posedge aclk);
        for (i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            levels.set_register(idx[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly complete writes with random content, some rejected writes and
    // idle ticks; always leaves the block idle.
    task automatic run_random(input int budget);
        int n;
        int roll;
        n = 0;
        while (n < budget) begin
            roll = $urandom_range(0, 99);
            if (!levels.busy()) begin
                if (roll < 85) begin
                    n++;
                end
                send_request(random_request(roll < 85 ? CMD_WRITE : CMD_TICK));
            end else begin
                if (roll >= 4) begin
                    n++;
                end
                send_request(random_request(roll < 4 ? CMD_WRITE : CMD_TICK));
            end
            if (gap_odds != 0 && $urandom_range(0, 149) == 0) begin
                drain();
            end
        end
        while (levels.busy()) begin
            send_request(random_request(CMD_TICK));
        end
    endtask

    initial begin
        levels = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        gap_odds   = 6;
        stall_odds = 6;

        // Reset timing: tick while idle, then a write with a rejected request
        // that runs into its third bit under the default lengths.
        send_request(random_request(CMD_TICK));
        start_write(3'd7, 4'hF, 28'hFFFFFFF, 135, 40);

        // Shorter lengths written mid-write take effect at once; a phase whose
        // count is already past its new length ends on the next tick.
        program_timing(16'd2, 16'd1, 16'd1, 16'd1, 16'd3);
        finish_write();
        send_request(random_request(CMD_TICK));

        // Zero lengths act as one tick; writes follow each other directly.
        program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_write(3'd0, 4'h0, 28'h0000000, 3);
        run_write(3'd5, 4'hA, 28'hAAAAAAA, 0);

        // Largest select setup and end gap, cut short once the write is under way.
        gap_odds   = 16;
        stall_odds = 16;
        program_timing(16'hFFFF, 16'd1, 16'd2, 16'd1, 16'hFFFF);
        start_write(3'd6, 4'h9, 28'h0F0F0F0, 20, 10);
        program_timing(16'd1, 16'd1, 16'd2, 16'd1, 16'd2);
        finish_write();

        // Random phases, each with fresh timing and random idling.
        while (sent_items < 700) begin
            gap_odds   = $urandom_range(0, 2) * 4;
            stall_odds = $urandom_range(0, 2) * 4;
            program_timing(random_length(), random_length(), random_length(),
                           random_length(), random_length());
            run_random(100);
        end

        // The last part runs without idling.
        gap_odds   = 0;
        stall_odds = 0;
        program_timing(random_length(), random_length(), random_length(),
                       random_length(), random_length());
        run_random(100);

        drain();
        repeat (5) @(posedge aclk);
        if (!levels.failed) begin
            $display("serial_register_write_master_unit: match");
        end else begin
            $display("serial_register_write_master_unit: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("serial_register_write_master_unit: mismatch");
        $finish;
    end

endmodule
